FILE: src/vga_text_adapter_registers_assert.svh
// ----------------------------------------------------------------------------
// VGA text adapter assertion macros
// Implication and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VGA_TEXT_ADAPTER_REGISTERS_ASSERT_SVH
`define VGA_TEXT_ADAPTER_REGISTERS_ASSERT_SVH
`ifndef SYNTH
`define VTA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define VTA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VTA_ASSERT_IMP(lbl, ante, cons, msg)
`define VTA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: src/vta_pkg.sv
// ----------------------------------------------------------------------------
// vta_pkg
// Types, constants and helper functions shared by the VGA text adapter.
// ----------------------------------------------------------------------------
`default_nettype none

package vta_pkg;

	localparam int TEXT_BYTES     = 4096;
	localparam int FONT_BYTES     = 2048;
	localparam int CRTC_REG_COUNT = 25;
	localparam int ATTR_REG_COUNT = 21;
	localparam int LINE_TOTAL     = 800;
	localparam int FRAME_LINES    = 449;

	localparam int TEXT_AW = $clog2(TEXT_BYTES);
	localparam int FONT_AW = $clog2(FONT_BYTES);
	localparam int CRTC_IW = $clog2(CRTC_REG_COUNT);
	localparam int ATTR_IW = $clog2(ATTR_REG_COUNT);
	localparam int REG_IW  = 5;
	localparam int LINE_W  = 10;
	localparam int FRAME_W = 9;

	// Floor reciprocals scaled by 4096 for the register index reduction.
	localparam int CRTC_RECIP = 4096 / CRTC_REG_COUNT;
	localparam int ATTR_RECIP = 4096 / ATTR_REG_COUNT;

	localparam logic [19:0] WIN_BASE = 20'hB8000;

	localparam logic [15:0] PORT_ATTR        = 16'h03C0;
	localparam logic [15:0] PORT_CRTC_IDX    = 16'h03D4;
	localparam logic [15:0] PORT_CRTC_DAT    = 16'h03D5;
	localparam logic [15:0] PORT_STATUS      = 16'h03DA;
	localparam logic [15:0] PORT_MONO_IDX    = 16'h03B4;
	localparam logic [15:0] PORT_MONO_DAT    = 16'h03B5;
	localparam logic [15:0] PORT_MONO_STATUS = 16'h03BA;

	localparam int HS_START = 656;
	localparam int HS_BACK  = 48;
	localparam int VS_START = 412;
	localparam int VS_BACK  = 35;

	localparam int SCREEN_W  = 640;
	localparam int SCREEN_H  = 200;
	localparam int TEXT_COLS = 80;

	typedef enum logic [3:0] {
		REQ_RDBYTE    = 4'd0,
		REQ_RDWORD    = 4'd1,
		REQ_WRBYTE    = 4'd2,
		REQ_WRWORD    = 4'd3,
		REQ_OUT8      = 4'd4,
		REQ_OUT16     = 4'd5,
		REQ_IN8       = 4'd6,
		REQ_IN16      = 4'd7,
		REQ_TICK      = 4'd8,
		REQ_PIXEL     = 4'd9,
		REQ_FONTWRITE = 4'd10
	} req_code_t;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [19:0] mem_address;
		logic [15:0] port;
		logic [15:0] data;
		logic [9:0]  pixel_x;
		logic [7:0]  pixel_y;
		logic [10:0] font_address;
	} vta_req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [23:0] pixel_color;
	} vta_rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_RD_HI,
		S_RD_END,
		S_WR_HI,
		S_PORT_HI,
		S_PIX_AT,
		S_PIX_GLYPH,
		S_PIX_COLOR,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		TA_CLEAR,
		TA_LO,
		TA_HI,
		TA_CHAR,
		TA_ATTR
	} text_sel_t;

	typedef struct packed {
		logic      load;
		logic      text_re;
		logic      text_we;
		text_sel_t text_sel;
		logic      clr_step;
		logic      cap_lo;
		logic      cap_hi;
		logic      cap_ch;
		logic      cap_at;
		logic      font_re;
		logic      font_we;
		logic      port_wr;
		logic      port_hi;
		logic      port_rd;
		logic      tick;
		logic      cap_color;
		logic      out_load;
	} vta_cmd_t;

	typedef struct packed {
		logic [3:0] req;
		logic       win_byte;
		logic       win_word;
		logic       pix_on;
		logic       clr_last;
		logic       out_free;
	} vta_stat_t;

	// Remainder of an 8-bit index by a small register count: reciprocal
	// estimate of the quotient, then at most one correction.
	function automatic logic [REG_IW-1:0] reduce_idx(input logic [7:0] v,
			input logic [5:0] m, input logic [7:0] recip);
		logic [15:0] prod;
		logic [7:0]  q;
		logic [8:0]  r;
		prod = 16'(v) * 16'(recip);
		q = 8'(prod >> 12);
		r = 9'(v) - 9'(q) * 9'(m);
		if (r >= 9'(m)) begin
			r = r - 9'(m);
		end
		return REG_IW'(r);
	endfunction

	function automatic logic [23:0] ega_bgr(input logic [3:0] c);
		logic [23:0] col;
		case (c)
			4'd0:    col = 24'h000000;
			4'd1:    col = 24'haa0000;
			4'd2:    col = 24'h00aa00;
			4'd3:    col = 24'haaaa00;
			4'd4:    col = 24'h0000aa;
			4'd5:    col = 24'haa00aa;
			4'd6:    col = 24'h0055aa;
			4'd7:    col = 24'haaaaaa;
			4'd8:    col = 24'h555555;
			4'd9:    col = 24'hff5555;
			4'd10:   col = 24'h55ff55;
			4'd11:   col = 24'hffff55;
			4'd12:   col = 24'h5555ff;
			4'd13:   col = 24'hff55ff;
			4'd14:   col = 24'h55ffff;
			default: col = 24'hffffff;
		endcase
		return col;
	endfunction

endpackage

`default_nettype wire

FILE: src/vta_ctrl.sv
// ----------------------------------------------------------------------------
// vta_ctrl
// Sequencer: clears the text buffer after reset, then steps each item
// through its memory, port or pixel operations and hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vga_text_adapter_registers_assert.svh"

module vta_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_stall,
	input  vta_pkg::vta_stat_t stat,
	output vta_pkg::vta_cmd_t  cmd
);
	import vta_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
				case (stat.req)
					REQ_RDBYTE: begin
						if (stat.win_byte) state_d = S_RD_END;
					end
					REQ_RDWORD: begin
						if (stat.win_word) state_d = S_RD_HI;
					end
					REQ_WRWORD: begin
						if (stat.win_word) state_d = S_WR_HI;
					end
					REQ_OUT16: begin
						state_d = S_PORT_HI;
					end
					REQ_PIXEL: begin
						if (stat.pix_on) state_d = S_PIX_AT;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_RD_HI:     state_d = S_RD_END;
			S_RD_END:    state_d = S_DONE;
			S_WR_HI:     state_d = S_DONE;
			S_PORT_HI:   state_d = S_DONE;
			S_PIX_AT:    state_d = S_PIX_GLYPH;
			S_PIX_GLYPH: state_d = S_PIX_COLOR;
			S_PIX_COLOR: state_d = S_DONE;
			S_DONE: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.text_sel = TA_LO;
		case (state_q)
			S_CLEAR: begin
				cmd.text_we  = 1'b1;
				cmd.text_sel = TA_CLEAR;
				cmd.clr_step = 1'b1;
			end
			S_IDLE: begin
				cmd.load = req_valid;
			end
			S_EXEC: begin
				case (stat.req)
					REQ_RDBYTE:    cmd.text_re = stat.win_byte;
					REQ_RDWORD:    cmd.text_re = stat.win_word;
					REQ_WRBYTE:    cmd.text_we = stat.win_byte;
					REQ_WRWORD:    cmd.text_we = stat.win_word;
					REQ_OUT8:      cmd.port_wr = 1'b1;
					REQ_OUT16:     cmd.port_wr = 1'b1;
					REQ_IN8:       cmd.port_rd = 1'b1;
					REQ_TICK:      cmd.tick    = 1'b1;
					REQ_PIXEL: begin
						cmd.text_re  = stat.pix_on;
						cmd.text_sel = TA_CHAR;
					end
					REQ_FONTWRITE: cmd.font_we = 1'b1;
					default:       cmd.load    = 1'b0;
				endcase
			end
			S_RD_HI: begin
				cmd.cap_lo   = 1'b1;
				cmd.text_re  = 1'b1;
				cmd.text_sel = TA_HI;
			end
			S_RD_END: begin
				if (stat.req == REQ_RDWORD) begin
					cmd.cap_hi = 1'b1;
				end else begin
					cmd.cap_lo = 1'b1;
				end
			end
			S_WR_HI: begin
				cmd.text_we  = 1'b1;
				cmd.text_sel = TA_HI;
			end
			S_PORT_HI: begin
				cmd.port_wr = 1'b1;
				cmd.port_hi = 1'b1;
			end
			S_PIX_AT: begin
				cmd.cap_ch   = 1'b1;
				cmd.text_re  = 1'b1;
				cmd.text_sel = TA_ATTR;
			end
			S_PIX_GLYPH: begin
				cmd.cap_at  = 1'b1;
				cmd.font_re = 1'b1;
			end
			S_PIX_COLOR: begin
				cmd.cap_color = 1'b1;
			end
			S_DONE: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

	`VTA_ASSERT_NXT(a_accept_exec, cmd.load, state_q == S_EXEC, "accepted item not executed")
	`VTA_ASSERT_NXT(a_clear_end, state_q == S_CLEAR && stat.clr_last, state_q == S_IDLE, "clear pass did not end")
	`VTA_ASSERT_IMP(a_one_text_op, cmd.text_we, !cmd.text_re, "text read and write together")
	`VTA_ASSERT_NXT(a_done_idle, cmd.out_load, state_q == S_IDLE && !req_stall, "not idle after result")

endmodule

`default_nettype wire

FILE: src/vta_datapath.sv
// ----------------------------------------------------------------------------
// vta_datapath
// Text buffer and font memories, CRTC and attribute registers, raster
// counters, result assembly and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vta_datapath (
	input  wire                clk,
	input  wire                arst_n,
	input  vta_pkg::vta_req_t  req,
	input  vta_pkg::vta_cmd_t  cmd,
	output vta_pkg::vta_stat_t stat,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output vta_pkg::vta_rsp_t  rsp
);
	import vta_pkg::*;

	vta_req_t item_q;

	logic [7:0] text_mem [TEXT_BYTES];
	logic [7:0] font_mem [FONT_BYTES];
	logic [7:0] text_rd_q;
	logic [7:0] font_rd_q;

	logic [TEXT_AW-1:0] clr_q;
	logic [TEXT_AW-1:0] text_addr;
	logic [7:0]         text_wdata;

	logic [19:0]        off_full;
	logic               above_base;
	logic [TEXT_AW-1:0] off_lo;
	logic [TEXT_AW-1:0] off_hi;
	logic [10:0]        char_pos;

	logic [7:0] ch_q;
	logic [7:0] at_q;
	logic [15:0] res_rd_q;
	logic [23:0] res_col_q;
	logic        rsp_valid_q;
	vta_rsp_t    rsp_q;

	logic [7:0]  crtc_index_q;
	logic [7:0]  crtc_regs_q [CRTC_REG_COUNT];
	logic        attr_phase_q;
	logic [7:0]  attr_index_q;
	logic [7:0]  attr_regs_q [ATTR_REG_COUNT];
	logic [REG_IW-1:0]  crtc_red;
	logic [REG_IW-1:0]  attr_red;
	logic [CRTC_IW-1:0] crtc_sel;
	logic [ATTR_IW-1:0] attr_sel;
	logic [15:0] wr_port;
	logic [7:0]  wr_byte;
	logic [15:0] port_rd_val;
	logic        status_port;

	logic [LINE_W-1:0]  line_q;
	logic [FRAME_W-1:0] frame_q;
	logic [LINE_W-1:0]  line_nx;
	logic [FRAME_W-1:0] frame_nx;
	logic               hsync_flag;
	logic               vsync_flag;

	logic        glyph_bit;
	logic [23:0] pix_col;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
	end

	// Window decode and text addresses.
	assign off_full   = item_q.mem_address - WIN_BASE;
	assign above_base = (item_q.mem_address >= WIN_BASE);
	assign off_lo     = off_full[TEXT_AW-1:0];
	assign off_hi     = off_lo + TEXT_AW'(1);
	assign char_pos   = 11'(item_q.pixel_y[7:3]) * 11'(TEXT_COLS) +
		11'(item_q.pixel_x[9:3]);

	always_comb begin
		case (cmd.text_sel)
			TA_CLEAR: text_addr = clr_q;
			TA_LO:    text_addr = off_lo;
			TA_HI:    text_addr = off_hi;
			TA_CHAR:  text_addr = TEXT_AW'({char_pos, 1'b0});
			TA_ATTR:  text_addr = TEXT_AW'({char_pos, 1'b1});
			default:  text_addr = off_lo;
		endcase
	end

	always_comb begin
		case (cmd.text_sel)
			TA_CLEAR: text_wdata = 8'h00;
			TA_HI:    text_wdata = item_q.data[15:8];
			default:  text_wdata = item_q.data[7:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.text_we) begin
			text_mem[text_addr] <= text_wdata;
		end
		if (cmd.text_re) begin
			text_rd_q <= text_mem[text_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + TEXT_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.font_we) begin
			font_mem[FONT_AW'(item_q.font_address)] <= item_q.data[7:0];
		end
		if (cmd.font_re) begin
			font_rd_q <= font_mem[FONT_AW'({ch_q, item_q.pixel_y[2:0]})];
		end
	end

	// Port registers.
	assign crtc_red = reduce_idx(crtc_index_q, 6'(CRTC_REG_COUNT), 8'(CRTC_RECIP));
	assign attr_red = reduce_idx(attr_index_q, 6'(ATTR_REG_COUNT), 8'(ATTR_RECIP));
	assign crtc_sel = crtc_red[CRTC_IW-1:0];
	assign attr_sel = attr_red[ATTR_IW-1:0];

	assign wr_port = cmd.port_hi ? item_q.port + 16'd1 : item_q.port;
	assign wr_byte = cmd.port_hi ? item_q.data[15:8] : item_q.data[7:0];
	assign status_port = item_q.port inside {PORT_STATUS, PORT_MONO_STATUS};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crtc_index_q <= '0;
			attr_phase_q <= 1'b0;
			attr_index_q <= '0;
			for (int i = 0; i < CRTC_REG_COUNT; i++) begin
				crtc_regs_q[i] <= '0;
			end
			for (int i = 0; i < ATTR_REG_COUNT; i++) begin
				attr_regs_q[i] <= '0;
			end
		end else if (cmd.port_wr) begin
			case (wr_port)
				PORT_ATTR: begin
					if (attr_phase_q) begin
						attr_regs_q[attr_sel] <= wr_byte;
					end else begin
						attr_index_q <= wr_byte;
					end
					attr_phase_q <= ~attr_phase_q;
				end
				PORT_CRTC_IDX, PORT_MONO_IDX: crtc_index_q <= wr_byte;
				PORT_CRTC_DAT, PORT_MONO_DAT: crtc_regs_q[crtc_sel] <= wr_byte;
				default: crtc_index_q <= crtc_index_q;
			endcase
		end else if (cmd.port_rd && status_port) begin
			// Reading input status resets the attribute flip-flop.
			attr_phase_q <= 1'b0;
		end
	end

	assign hsync_flag = (line_q < LINE_W'(HS_START)) ||
		(line_q >= LINE_W'(LINE_TOTAL - HS_BACK));
	assign vsync_flag = (frame_q < FRAME_W'(VS_START)) ||
		(frame_q >= FRAME_W'(FRAME_LINES - VS_BACK));

	always_comb begin
		case (item_q.port)
			PORT_STATUS, PORT_MONO_STATUS:
				port_rd_val = {12'b0, vsync_flag, 2'b0, hsync_flag};
			PORT_CRTC_IDX, PORT_MONO_IDX:
				port_rd_val = {8'b0, crtc_index_q};
			PORT_CRTC_DAT, PORT_MONO_DAT:
				port_rd_val = {8'b0, crtc_regs_q[crtc_sel]};
			default:
				port_rd_val = '0;
		endcase
	end

	// Raster position advanced by pixel ticks.
	assign line_nx  = line_q + LINE_W'(1);
	assign frame_nx = frame_q + FRAME_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q  <= '0;
			frame_q <= '0;
		end else if (cmd.tick) begin
			if (line_nx >= LINE_W'(LINE_TOTAL)) begin
				line_q <= '0;
				if (frame_nx >= FRAME_W'(FRAME_LINES)) begin
					frame_q <= '0;
				end else begin
					frame_q <= frame_nx;
				end
			end else begin
				line_q <= line_nx;
			end
		end
	end

	// Glyph bits are stored with the leftmost pixel in bit 7.
	assign glyph_bit = font_rd_q[~item_q.pixel_x[2:0]];
	assign pix_col   = glyph_bit ? ega_bgr(at_q[3:0]) : ega_bgr(at_q[7:4]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_rd_q  <= '0;
			res_col_q <= '0;
		end else begin
			if (cmd.cap_lo) res_rd_q[7:0] <= text_rd_q;
			if (cmd.cap_hi) res_rd_q[15:8] <= text_rd_q;
			if (cmd.port_rd) res_rd_q <= port_rd_val;
			if (cmd.cap_color) res_col_q <= pix_col;
		end
		if (cmd.cap_ch) ch_q <= text_rd_q;
		if (cmd.cap_at) at_q <= text_rd_q;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.read_data   <= res_rd_q;
			rsp_q.pixel_color <= res_col_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign stat.req      = item_q.req_type;
	assign stat.win_byte = above_base && (off_full < 20'(TEXT_BYTES));
	assign stat.win_word = above_base && (off_full < 20'(TEXT_BYTES - 1));
	assign stat.pix_on   = (item_q.pixel_x < 10'(SCREEN_W)) && (item_q.pixel_y < 8'(SCREEN_H));
	assign stat.clr_last = (clr_q == TEXT_AW'(TEXT_BYTES - 1));
	assign stat.out_free = !rsp_valid_q || !rsp_stall;

endmodule

`default_nettype wire

FILE: src/vga_text_adapter_registers.sv
// ----------------------------------------------------------------------------
// vga_text_adapter_registers
// 80x25 colour text adapter: text buffer window, CRTC and attribute ports,
// input status from a raster counter, and per-pixel colour lookup.
//
//   channel  direction  payload     handshake
//   req      in         vta_req_t   req_valid / req_stall
//   rsp      out        vta_rsp_t   rsp_valid / rsp_stall
//
// After reset the text buffer is cleared, one byte per cycle over all TEXT_BYTES
// (4096) bytes, and no item is accepted until then.
// The result is loaded in S_DONE, after the execute state: a read waits
// for the registered memory data, a word or out16 moves a second byte, and a
// pixel query reads character, attribute and font byte in turn.
// An item goes back to idle before the next is accepted; a stalled result holds
// only the last step of the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module vga_text_adapter_registers (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_stall,
	input  vta_pkg::vta_req_t req,
	output logic              rsp_valid,
	input  wire               rsp_stall,
	output vta_pkg::vta_rsp_t rsp
);
	import vta_pkg::*;

	vta_cmd_t  cmd;
	vta_stat_t stat;

	vta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	vta_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
